@@ rtl/rfs_pkg.sv @@
// Shared types and constants of the Rabin fingerprint stream block.
`default_nettype none
package rfs_pkg;

  localparam int WORD_W      = 64;
  localparam int NUM_POWERS  = 72;
  localparam int POW_IDX_W   = $clog2(NUM_POWERS);
  localparam int QUEUE_DEPTH = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int DEG_W       = 4;

  localparam logic [WORD_W-1:0] X_POW_0    = 64'h8000_0000_0000_0000;
  localparam logic [DEG_W-1:0]  DEG_RESET  = 4'd8;
  localparam logic [DEG_W-1:0]  DEG_MAX    = 4'd8;
  localparam int                START_POW  = 64;
  localparam int                FOLD_BASE  = 71;
  localparam int                REDUCE_TOP = 63;

  localparam logic [CFG_IDX_W-1:0] REG_POLY_LOW_TERMS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEGREE_BYTES   = 2'd1;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [NUM_POWERS-1:0][WORD_W-1:0] power_tab_t;

  typedef struct packed {
    logic       busy;
    logic [2:0] reduce_bytes;
  } pow_stat_t;

  typedef struct packed {
    logic  valid;
    word_t value;
  } push_t;

endpackage
`default_nettype wire

@@ rtl/rfs_powers.sv @@
// Configuration registers and the sequential derivation of the x^i mod P table.
`default_nettype none
module rfs_powers import rfs_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [WORD_W-1:0]    cfg_data,
  output power_tab_t                tab,
  output pow_stat_t                 stat
);

  word_t                poly;
  logic [DEG_W-1:0]     degree;
  word_t                p;
  logic [POW_IDX_W-1:0] idx;
  logic                 busy;

  logic [DEG_W-1:0] deg_eff;
  logic [6:0]       top_sum;
  logic [5:0]       top_idx;
  logic [DEG_W-1:0] nb_wide;
  word_t            p_next;
  logic             reg_hit;

  always_comb begin
    if (degree == '0) begin
      deg_eff = DEG_W'(1);
    end else if (degree > DEG_MAX) begin
      deg_eff = DEG_MAX;
    end else begin
      deg_eff = degree;
    end
    top_sum = 7'd64 - {deg_eff, 3'b000};
    top_idx = top_sum[5:0];
    nb_wide = DEG_MAX - deg_eff;
    p_next  = (p >> 1) ^ (p[top_idx] ? poly : '0);
    reg_hit = cfg_write &&
              ((cfg_index == REG_POLY_LOW_TERMS) || (cfg_index == REG_DEGREE_BYTES));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      poly   <= '0;
      degree <= DEG_RESET;
      busy   <= 1'b1;
      idx    <= '0;
      p      <= X_POW_0;
    end else if (reg_hit) begin
      if (cfg_index == REG_POLY_LOW_TERMS) begin
        poly <= cfg_data;
      end else begin
        degree <= cfg_data[DEG_W-1:0];
      end
      busy <= 1'b1;
      idx  <= '0;
      p    <= X_POW_0;
    end else if (busy) begin
      p <= p_next;
      if (idx == POW_IDX_W'(NUM_POWERS - 1)) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst && !reg_hit && busy) begin
      tab[idx] <= p;
    end
  end

  assign stat.busy         = busy;
  assign stat.reduce_bytes = nb_wide[2:0];

endmodule
`default_nettype wire

@@ rtl/rfs_front.sv @@
// Input stage: message start, per-byte fold and hand-off of finished values.
`default_nettype none
module rfs_front import rfs_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] data_byte,
  input  wire logic       byte_present,
  input  wire logic       first_item,
  input  wire logic       use_seed,
  input  wire word_t      seed_value,
  input  wire logic       last_item,
  input  wire power_tab_t tab,
  input  wire pow_stat_t  stat,
  input  wire logic       q_full,
  output push_t           push
);

  word_t running;
  word_t base;
  word_t f;
  word_t fold;
  word_t running_next;
  logic  accept;

  always_comb begin
    if (first_item) begin
      base = use_seed ? seed_value : tab[START_POW];
    end else begin
      base = running;
    end
    f    = base ^ {{(WORD_W-8){1'b0}}, data_byte};
    fold = f >> 8;
    for (int k = 0; k < 8; k++) begin
      if (f[k]) begin
        fold = fold ^ tab[FOLD_BASE - k];
      end
    end
    running_next = byte_present ? fold : base;
  end

  assign in_ready    = !stat.busy && !q_full;
  assign accept      = in_valid && in_ready;
  assign push.valid  = accept && last_item;
  assign push.value  = running_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= '0;
    end else if (accept) begin
      running <= running_next;
    end
  end

endmodule
`default_nettype wire

@@ rtl/rfs_queue.sv @@
// Short queue of unreduced fingerprints between the front and back stages.
`default_nettype none
module rfs_queue import rfs_pkg::*; #(
  parameter int Depth = QUEUE_DEPTH
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire push_t push,
  output logic       full,
  output logic       head_valid,
  output word_t      head,
  input  wire logic  pop
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  word_t            mem [Depth];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;

  assign full       = (count == CntW'(Depth));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem[wr_ptr] <= push.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CntW'(push.valid) - CntW'(pop);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(Depth))
    else $error("queue count above depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(push.valid && full))
    else $error("item pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from empty queue");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> count == $past(count) + CntW'($past(push.valid)) - CntW'($past(pop)))
    else $error("queue count out of step with push and pop");

endmodule
`default_nettype wire

@@ rtl/rfs_back.sv @@
// Output stage: two-step reduction of terms x^D..x^63 and the result register.
`default_nettype none
module rfs_back import rfs_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       head_valid,
  input  wire word_t      head,
  output logic            pop,
  input  wire power_tab_t tab,
  input  wire pow_stat_t  stat,
  output logic            out_valid,
  input  wire logic       out_ready,
  output word_t           fingerprint
);

  word_t       part [8];
  word_t       part_next [8];
  logic        a_valid;
  logic        a_ready;
  logic        b_ready;
  logic [5:0]  keep_shift;
  word_t       sum;

  always_comb begin
    keep_shift = {stat.reduce_bytes, 3'b000};
    for (int n = 0; n < 7; n++) begin
      part_next[n] = '0;
      if (3'(n) < stat.reduce_bytes) begin
        for (int k = 0; k < 8; k++) begin
          if (head[8*n + k]) begin
            part_next[n] = part_next[n] ^ tab[REDUCE_TOP - 8*n - k];
          end
        end
      end
    end
    part_next[7] = head & ({WORD_W{1'b1}} << keep_shift);
    sum = '0;
    for (int n = 0; n < 8; n++) begin
      sum = sum ^ part[n];
    end
  end

  assign b_ready = !out_valid || out_ready;
  assign a_ready = !a_valid || b_ready;
  assign pop     = head_valid && a_ready;

  always_ff @(posedge clk) begin
    if (pop) begin
      part <= part_next;
    end
    if (a_valid && b_ready) begin
      fingerprint <= sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid <= head_valid;
      end
      if (b_ready) begin
        out_valid <= a_valid;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/rabin_fingerprint_stream.sv @@
// Top level of the Rabin fingerprint stream block.
// Takes one byte item per cycle while in_ready is high and returns one fingerprint
// per item marked last_item; that value is registered in the queue, the reduction
// part registers and the output register in turn. The byte fold is a combinational
// XOR of up to eight table entries onto the running value; finished values wait in
// a small queue (QueueDepth entries) and are reduced in two pipeline stages, the
// second of which is the output register. After reset, and after every write to
// poly_low_terms or degree_bytes, the table of x^0..x^71 mod P is rebuilt one entry
// per cycle while in_ready is held low; writes are taken at any time.
`default_nettype none
module rabin_fingerprint_stream import rfs_pkg::*; #(
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [WORD_W-1:0]    cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [7:0]           data_byte,
  input  wire logic                 byte_present,
  input  wire logic                 first_item,
  input  wire logic                 use_seed,
  input  wire logic [WORD_W-1:0]    seed_value,
  input  wire logic                 last_item,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [WORD_W-1:0]         fingerprint
);

  power_tab_t tab;
  pow_stat_t  stat;
  push_t      push;
  logic       q_full;
  logic       head_valid;
  word_t      head;
  logic       pop;

  rfs_powers u_powers (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tab       (tab),
    .stat      (stat)
  );

  rfs_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .byte_present (byte_present),
    .first_item   (first_item),
    .use_seed     (use_seed),
    .seed_value   (seed_value),
    .last_item    (last_item),
    .tab          (tab),
    .stat         (stat),
    .q_full       (q_full),
    .push         (push)
  );

  rfs_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  rfs_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head        (head),
    .pop         (pop),
    .tab         (tab),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .fingerprint (fingerprint)
  );

endmodule
`default_nettype wire

@@ verif/testbench.sv @@
// Self-checking testbench for the Rabin fingerprint stream block.
`timescale 1ns / 1ps

module testbench;
  import rfs_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam int DRAIN_CYCLES = 8;

  class fingerprint_book;
    word_t poly_word;
    logic [DEG_W-1:0] deg_reg;
    word_t running_fp;
    word_t powers[NUM_POWERS];
    word_t expected_fps[$];
    int errors;

    function new();
      poly_word = '0;
      deg_reg = DEG_RESET;
      running_fp = '0;
      errors = 0;
      build_powers();
    endfunction

    task report(string msg);
      if (errors < 40) $display("ERROR at %0t ns: %s", $time, msg);
      errors++;
    endtask

    function int deg_bytes();
      if (deg_reg == 0) return 1;
      if (deg_reg > DEG_MAX) return int'(DEG_MAX);
      return int'(deg_reg);
    endfunction

    function void build_powers();
      word_t top;
      word_t p;
      logic carry;
      top = X_POW_0 >> (deg_bytes() * 8 - 1);
      p = X_POW_0;
      for (int i = 0; i < NUM_POWERS; i++) begin
        powers[i] = p;
        carry = (p & top) != '0;
        p = p >> 1;
        if (carry) p = p ^ poly_word;
      end
    endfunction

    function word_t fold_byte(logic [7:0] b, int base);
      word_t v;
      v = '0;
      for (int k = 0; k < 8; k++)
        if (b[k]) v = v ^ powers[(base - k) % NUM_POWERS];
      return v;
    endfunction

    function word_t reduce_fp(word_t f);
      int nb;
      word_t keep;
      word_t acc;
      nb = 8 - deg_bytes();
      keep = f & ({WORD_W{1'b1}} << (8 * nb));
      acc = '0;
      for (int n = 0; n < nb; n++) begin
        acc = acc ^ fold_byte(f[7:0], REDUCE_TOP - 8 * n);
        f = f >> 8;
      end
      return keep ^ acc;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, word_t value);
      case (idx)
        REG_POLY_LOW_TERMS: poly_word = value;
        REG_DEGREE_BYTES: deg_reg = value[DEG_W-1:0];
        default: return;
      endcase
      build_powers();
    endfunction

    function void note_item(logic [7:0] b, logic present, logic is_first, logic seeded,
                            word_t seed, logic is_last);
      word_t f;
      if (is_first) running_fp = seeded ? seed : powers[START_POW];
      if (present) begin
        f = running_fp ^ {56'd0, b};
        running_fp = (f >> 8) ^ fold_byte(f[7:0], FOLD_BASE);
      end
      if (is_last) expected_fps.push_back(reduce_fp(running_fp));
    endfunction

    task check_fingerprint(word_t got);
      word_t want;
      if (expected_fps.size() == 0) begin
        report($sformatf("unexpected fingerprint %h", got));
      end else begin
        want = expected_fps.pop_front();
        if (got !== want) report($sformatf("fingerprint %h, expected %h", got, want));
      end
    endtask

    function int pending();
      return expected_fps.size();
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WORD_W-1:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic [7:0] data_byte;
  logic byte_present;
  logic first_item;
  logic use_seed;
  logic [WORD_W-1:0] seed_value;
  logic last_item;
  logic out_valid;
  logic out_ready;
  logic [WORD_W-1:0] fingerprint;

  fingerprint_book book;
  bit calm = 1'b0;
  int items_sent = 0;
  int quiet_left = 0;

  rabin_fingerprint_stream u_top (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .data_byte(data_byte),
    .byte_present(byte_present),
    .first_item(first_item),
    .use_seed(use_seed),
    .seed_value(seed_value),
    .last_item(last_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .fingerprint(fingerprint)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_write) book.write_reg(cfg_index, cfg_data);
      if (in_valid && in_ready)
        book.note_item(data_byte, byte_present, first_item, use_seed, seed_value, last_item);
      if (out_valid && out_ready) book.check_fingerprint(fingerprint);
    end
  end

  initial begin
    out_ready = 1'b1;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 15) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
        out_ready = 1'b1;
      end else if ($urandom_range(0, 63) == 0) begin
        repeat ($urandom_range(20, 80)) @(negedge clk);
      end
    end
  end

  function automatic word_t pick_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return X_POW_0;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_item(input logic [7:0] b, input logic present, input logic is_first,
                           input logic seeded, input word_t seed, input logic is_last);
    if (quiet_left > 0) begin
      quiet_left--;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end else if ($urandom_range(0, 39) == 0) begin
      quiet_left = $urandom_range(30, 100);
    end
    in_valid = 1'b1;
    data_byte = b;
    byte_present = present;
    first_item = is_first;
    use_seed = seeded;
    seed_value = seed;
    last_item = is_last;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (present || is_first || is_last) items_sent++;
  endtask

  task automatic send_noise();
    send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), pick_word(),
              1'($urandom_range(0, 1)));
  endtask

  // broken: drop the start or the end of the message
  task automatic send_message(input bit broken);
    int len;
    logic seeded;
    word_t seed;
    logic drop_first;
    logic drop_last;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
    seeded = 1'($urandom_range(0, 1));
    seed = pick_word();
    drop_first = broken && $urandom_range(0, 1);
    drop_last = broken && !drop_first;
    if (len == 0) begin
      send_item(8'($urandom_range(0, 255)), 1'b0, !drop_first, seeded, seed, !drop_last);
    end else begin
      for (int k = 0; k < len; k++)
        send_item(8'($urandom_range(0, 255)), k == 0 || $urandom_range(0, 15) != 0,
                  k == 0 && !drop_first, k == 0 ? seeded : logic'($urandom_range(0, 1)),
                  k == 0 ? seed : pick_word(), k == len - 1 && !drop_last);
    end
  endtask

  task automatic run_random(input int count);
    int target;
    int pick;
    target = items_sent + count;
    while (items_sent < target) begin
      pick = $urandom_range(0, 19);
      if (pick < 3) send_noise();
      else send_message(pick < 5);
    end
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (book.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input word_t value);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
  endtask

  task automatic configure(input word_t poly, input word_t deg_word);
    drain();
    write_reg(REG_POLY_LOW_TERMS, poly);
    write_reg(REG_DEGREE_BYTES, deg_word);
    cfg_write = 1'b0;
  endtask

  task automatic run_directed();
    send_item(8'hff, 1'b1, 1'b0, 1'b0, '0, 1'b1);
    send_item(8'h00, 1'b0, 1'b1, 1'b0, '1, 1'b1);
    send_item(8'h5a, 1'b0, 1'b1, 1'b1, '1, 1'b1);
    send_item(8'h00, 1'b0, 1'b1, 1'b1, '0, 1'b1);
    send_item(8'h00, 1'b1, 1'b1, 1'b0, '0, 1'b0);
    send_item(8'hff, 1'b1, 1'b0, 1'b0, '0, 1'b0);
    send_item(8'h80, 1'b1, 1'b0, 1'b1, '1, 1'b0);
    send_item(8'h3c, 1'b0, 1'b0, 1'b0, '0, 1'b0);
    send_item(8'h01, 1'b1, 1'b0, 1'b0, '0, 1'b1);
    send_item(8'ha5, 1'b1, 1'b0, 1'b0, '0, 1'b1);
    send_item(8'h00, 1'b0, 1'b0, 1'b0, '0, 1'b0);
    send_item(8'h77, 1'b1, 1'b0, 1'b1, 64'h0123_4567_89ab_cdef, 1'b1);
    send_item(8'hc3, 1'b1, 1'b1, 1'b1, X_POW_0, 1'b0);
    send_item(8'hff, 1'b1, 1'b0, 1'b0, '1, 1'b0);
    send_item(8'h00, 1'b1, 1'b0, 1'b0, '0, 1'b1);
    send_item(8'hff, 1'b1, 1'b1, 1'b1, '1, 1'b1);
    send_item(8'h00, 1'b0, 1'b0, 1'b0, '0, 1'b1);
  endtask

  initial begin
    book = new();
    cfg_write = 1'b0;
    cfg_index = REG_POLY_LOW_TERMS;
    cfg_data = '0;
    in_valid = 1'b0;
    data_byte = '0;
    byte_present = 1'b0;
    first_item = 1'b0;
    use_seed = 1'b0;
    seed_value = '0;
    last_item = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    run_directed();
    run_random(110);
    configure({$urandom, $urandom}, 64'd8);
    run_directed();
    run_random(160);
    configure({$urandom, $urandom}, 64'd1);
    run_random(180);
    drain();
    write_reg(REG_SPARE_A, {$urandom, $urandom});
    write_reg(REG_SPARE_B, {$urandom, $urandom});
    write_reg(REG_DEGREE_BYTES, 64'd0);
    cfg_write = 1'b0;
    run_random(180);
    configure('1, {$urandom, $urandom} | 64'hf);
    run_random(180);
    configure({$urandom, $urandom}, 64'd4);
    run_random(180);
    configure('0, 64'd9);
    run_random(150);
    configure(X_POW_0 | {$urandom, $urandom},
              {$urandom, 28'($urandom), 4'(0)} | 64'($urandom_range(0, 15)));
    run_random(150);
    configure({$urandom, $urandom}, 64'($urandom_range(2, 7)));
    run_random(90);
    calm = 1'b1;
    run_random(90);

    in_valid = 1'b0;
    for (int n = 0; n < 2000 && book.pending() != 0; n++) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (book.pending() != 0)
      book.report($sformatf("%0d fingerprints never arrived", book.pending()));
    if (book.errors == 0) begin
      $display("rabin_fingerprint_stream test passed");
    end else begin
      $display("rabin_fingerprint_stream test failed");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("rabin_fingerprint_stream test failed");
    $finish;
  end

endmodule
